### src/sc2a_pkg.sv
package sc2a_pkg;

  // Set-1 modifier codes
  localparam logic [7:0] CodeCtrlMake    = 8'h1D;
  localparam logic [7:0] CodeCtrlBreak   = 8'h9D;
  localparam logic [7:0] CodeLshiftMake  = 8'h2A;
  localparam logic [7:0] CodeRshiftMake  = 8'h36;
  localparam logic [7:0] CodeLshiftBreak = 8'hAA;
  localparam logic [7:0] CodeRshiftBreak = 8'hB6;
  localparam logic [7:0] CodeCapsMake    = 8'h3A;

  // Key table geometry and character widths
  localparam int          KeyTableSize = 88;
  localparam int          CharWidth    = 7;
  localparam int          CodeWidth    = 8;
  localparam logic [6:0]  CtrlMask     = 7'h1F;

  typedef logic [CharWidth-1:0] char_t;
  typedef logic [CodeWidth-1:0] code_t;

  // Keyboard modifier state
  typedef struct packed {
    logic shift_held;
    logic ctrl_held;
    logic caps_on;
  } flags_t;

  // Unshifted characters, indexed by make code; zero means no character
  function automatic char_t key_plain(input logic [6:0] idx);
    char_t c;
    unique case (idx)
      7'd2:  c = 7'h31;
      7'd3:  c = 7'h32;
      7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;
      7'd7:  c = 7'h36;
      7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;
      7'd10: c = 7'h39;
      7'd11: c = 7'h30;
      7'd12: c = 7'h2D;
      7'd13: c = 7'h3D;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h71;
      7'd17: c = 7'h77;
      7'd18: c = 7'h65;
      7'd19: c = 7'h72;
      7'd20: c = 7'h74;
      7'd21: c = 7'h79;
      7'd22: c = 7'h75;
      7'd23: c = 7'h69;
      7'd24: c = 7'h6F;
      7'd25: c = 7'h70;
      7'd26: c = 7'h5B;
      7'd27: c = 7'h5D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h61;
      7'd31: c = 7'h73;
      7'd32: c = 7'h64;
      7'd33: c = 7'h66;
      7'd34: c = 7'h67;
      7'd35: c = 7'h68;
      7'd36: c = 7'h6A;
      7'd37: c = 7'h6B;
      7'd38: c = 7'h6C;
      7'd39: c = 7'h3B;
      7'd40: c = 7'h27;
      7'd41: c = 7'h60;
      7'd43: c = 7'h5C;
      7'd44: c = 7'h7A;
      7'd45: c = 7'h78;
      7'd46: c = 7'h63;
      7'd47: c = 7'h76;
      7'd48: c = 7'h62;
      7'd49: c = 7'h6E;
      7'd50: c = 7'h6D;
      7'd51: c = 7'h2C;
      7'd52: c = 7'h2E;
      7'd53: c = 7'h2F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Shifted characters, indexed by make code; zero means no character
  function automatic char_t key_upper(input logic [6:0] idx);
    char_t c;
    unique case (idx)
      7'd2:  c = 7'h21;
      7'd3:  c = 7'h40;
      7'd4:  c = 7'h23;
      7'd5:  c = 7'h24;
      7'd6:  c = 7'h25;
      7'd7:  c = 7'h5E;
      7'd8:  c = 7'h26;
      7'd9:  c = 7'h2A;
      7'd10: c = 7'h28;
      7'd11: c = 7'h29;
      7'd12: c = 7'h5F;
      7'd13: c = 7'h2B;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h51;
      7'd17: c = 7'h57;
      7'd18: c = 7'h45;
      7'd19: c = 7'h52;
      7'd20: c = 7'h54;
      7'd21: c = 7'h59;
      7'd22: c = 7'h55;
      7'd23: c = 7'h49;
      7'd24: c = 7'h4F;
      7'd25: c = 7'h50;
      7'd26: c = 7'h7B;
      7'd27: c = 7'h7D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h41;
      7'd31: c = 7'h53;
      7'd32: c = 7'h44;
      7'd33: c = 7'h46;
      7'd34: c = 7'h47;
      7'd35: c = 7'h48;
      7'd36: c = 7'h4A;
      7'd37: c = 7'h4B;
      7'd38: c = 7'h4C;
      7'd39: c = 7'h3A;
      7'd40: c = 7'h22;
      7'd41: c = 7'h7E;
      7'd43: c = 7'h7C;
      7'd44: c = 7'h5A;
      7'd45: c = 7'h58;
      7'd46: c = 7'h43;
      7'd47: c = 7'h56;
      7'd48: c = 7'h42;
      7'd49: c = 7'h4E;
      7'd50: c = 7'h4D;
      7'd51: c = 7'h3C;
      7'd52: c = 7'h3E;
      7'd53: c = 7'h3F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic is_letter(input char_t c);
    return ((c >= 7'h61) && (c <= 7'h7A)) || ((c >= 7'h41) && (c <= 7'h5A));
  endfunction

endpackage

### src/sc2a_lookup.sv
module sc2a_lookup (
  input  sc2a_pkg::code_t  code,
  input  sc2a_pkg::flags_t flags,
  output sc2a_pkg::flags_t flags_next,
  output logic             hit,
  output sc2a_pkg::char_t  ascii_char
);

  logic            is_mod;
  logic            in_range;
  sc2a_pkg::char_t raw;

  // Update modifier flags
  always_comb begin
    flags_next = flags;
    is_mod     = 1'b1;
    unique case (code)
      sc2a_pkg::CodeCtrlBreak:   flags_next.ctrl_held  = 1'b0;
      sc2a_pkg::CodeLshiftBreak,
      sc2a_pkg::CodeRshiftBreak: flags_next.shift_held = 1'b0;
      sc2a_pkg::CodeCtrlMake:    flags_next.ctrl_held  = 1'b1;
      sc2a_pkg::CodeLshiftMake,
      sc2a_pkg::CodeRshiftMake:  flags_next.shift_held = 1'b1;
      sc2a_pkg::CodeCapsMake:    flags_next.caps_on    = ~flags.caps_on;
      default:                   is_mod = 1'b0;
    endcase
  end

  // Pick the table and apply the ctrl mask to letters
  assign in_range = (code < sc2a_pkg::code_t'(sc2a_pkg::KeyTableSize));
  assign raw = (flags.shift_held ^ flags.caps_on) ? sc2a_pkg::key_upper(code[6:0])
                                                  : sc2a_pkg::key_plain(code[6:0]);
  assign hit = !is_mod && in_range && (raw != '0);
  assign ascii_char = (flags.ctrl_held && sc2a_pkg::is_letter(raw))
                    ? (raw & sc2a_pkg::CtrlMask) : raw;

endmodule

### src/scancode_to_ascii_decoder.sv
// Set-1 keyboard scancode to ASCII decoder. Each input word is one raw scancode byte;
// each output word is one 7-bit ASCII character. Shift, ctrl and caps lock codes only
// update internal flags; break codes, codes 88 and up and keys with no character give
// no output word. Shift XOR caps lock selects the shifted character for every key, and
// ctrl turns letters into control codes. A byte passes through the input register, then the
// result register, and one byte can be accepted every cycle while the output side keeps up;
// the result register is the only point of backpressure.
module scancode_to_ascii_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] scancode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [6:0] ascii_char, [7] zero
);

  logic             in_valid;
  sc2a_pkg::code_t  in_code;
  sc2a_pkg::flags_t flags;
  sc2a_pkg::flags_t flags_next;
  logic             hit;
  sc2a_pkg::char_t  res_char;
  sc2a_pkg::char_t  out_char;
  logic             out_valid;
  logic             advance;

  sc2a_lookup u_lookup (
    .code       (in_code),
    .flags      (flags),
    .flags_next (flags_next),
    .hit        (hit),
    .ascii_char (res_char)
  );

  // Retire the held word when it yields nothing or the result slot frees up
  assign advance       = in_valid && (!hit || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register and modifier flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      flags    <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        flags <= flags_next;
      end
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_code <= s_axis_tdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && hit) begin
      out_char <= res_char;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_char};

endmodule

### src/sc2a_checker.sv
module sc2a_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Output slot empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // Only a full, stalled result register blocks input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // Emitted characters are nonzero 7-bit codes
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7] == 1'b0) && (m_axis_tdata != 8'h00))
    else $error("output character out of range");

endmodule

bind scancode_to_ascii_decoder sc2a_checker u_sc2a_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
